@@ rtl/lscfd_pkg.sv @@
// Shared types, constants and byte builders for the LED strip command frame driver.
package lscfd_pkg;

  // Default strip capacity and register defaults
  localparam int unsigned LSCFD_MAX_LEDS = 32;
  localparam int unsigned LED_COUNT_W    = 6;
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 6'd32;

  // Level threshold: a colour is on when its level is above this value
  localparam logic [7:0] LVL_THRESHOLD = 8'd127;
  localparam logic [7:0] LATCH_EN      = 8'h80;

  // Colour store entry: bit 2 red, bit 1 green, bit 0 blue
  localparam int unsigned COLOUR_W = 3;

  // Input word layout
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 3;

  typedef enum logic [2:0] {
    ACT_SET_LED    = 3'd0,
    ACT_UPDATE     = 3'd1,
    ACT_BLANK      = 3'd2,
    ACT_PUSH_COL   = 3'd3,
    ACT_PUSH_SPACE = 3'd4
  } action_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // Build the latch-enabled command byte for a stored on/off colour
  function automatic logic [7:0] stored_byte(input logic [COLOUR_W-1:0] bits);
    stored_byte = {1'b1, 1'b0, 1'b0, bits[1], 1'b0, bits[2], 1'b0, bits[0]};
  endfunction

  // Pack three 2-bit commands with optional double fade speed
  function automatic logic [7:0] colour_byte(input logic [1:0] rc, input logic [1:0] gc,
                                             input logic [1:0] bc, input logic dbl);
    colour_byte = {1'b1, dbl, gc, rc, bc};
  endfunction

endpackage

@@ rtl/lscfd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lscfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/led_strip_command_frame_driver.sv @@
// Top level: accepts LED strip requests and streams the resulting command bytes.
// A push word passes the pending stage, then the output register. An update or blank
//   walks the strip with one store read per LED (n reads, n the effective LED count,
//   1..MAX_LEDS); each read passes the pending stage and the output register, one byte
//   per cycle while the output is not stalled. No request is taken during the walk.
// Reset: control clears at once, led_count returns to 32, valid bits make every LED read off.
module led_strip_command_frame_driver
  import lscfd_pkg::*;
#(
  parameter int unsigned MAX_LEDS = LSCFD_MAX_LEDS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: led_count
  input  logic                   cfg_we_i,
  input  logic [LED_COUNT_W-1:0] cfg_wdata_i,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] led_index, [12:5] red_level, [20:13] green_level, [28:21] blue_level,
  // [30:29] red_cmd, [32:31] green_cmd, [34:33] blue_cmd, [35] double_speed, [39:36] zero
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] action
  input  logic [S_TUSER_W-1:0]   s_axis_tuser,
  // Command byte stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] command_byte
  output logic [7:0]             m_axis_tdata,
  // [0] latch_after
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

  // ---------------------------------------------------------------------------
  // Unpack the request word
  // ---------------------------------------------------------------------------
  logic [4:0] s_idx;
  logic [7:0] s_red, s_green, s_blue;
  logic [1:0] s_rc, s_gc, s_bc;
  logic       s_dbl;
  action_e    s_act;

  assign s_idx   = s_axis_tdata[4:0];
  assign s_red   = s_axis_tdata[12:5];
  assign s_green = s_axis_tdata[20:13];
  assign s_blue  = s_axis_tdata[28:21];
  assign s_rc    = s_axis_tdata[30:29];
  assign s_gc    = s_axis_tdata[32:31];
  assign s_bc    = s_axis_tdata[34:33];
  assign s_dbl   = s_axis_tdata[35];
  assign s_act   = action_e'(s_axis_tuser);

  // ---------------------------------------------------------------------------
  // Configuration register and effective LED count
  // ---------------------------------------------------------------------------
  logic [LED_COUNT_W-1:0] led_count_q;
  logic [CNT_W-1:0]       n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LED_COUNT_RST;
    end else if (cfg_we_i) begin
      led_count_q <= cfg_wdata_i;
    end
  end

  // Clamp to 1..MAX_LEDS
  always_comb begin
    if (32'(led_count_q) > MAX_LEDS) begin
      n_eff = CNT_W'(MAX_LEDS);
    end else if (led_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else begin
      n_eff = CNT_W'(led_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline: read issue -> pending stage (RAM data) -> output register
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             blank_q, blank_d;

  logic             pend_q, pend_d;
  logic             pend_ram_q, pend_ram_d;   // byte comes from the colour store
  logic             pend_live_q, pend_live_d; // entry was written since reset
  logic [7:0]       pend_byte_q, pend_byte_d;
  logic             pend_latch_q, pend_latch_d;
  logic             pend_fin_q, pend_fin_d;

  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_latch_q, out_latch_d;
  logic             out_fin_q, out_fin_d;

  logic [MAX_LEDS-1:0] vld_q;

  logic                s_acc;
  logic                pend_mv;
  logic                pend_free;
  logic                rd_go;
  logic                rd_last;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [COLOUR_W-1:0] wr_colour;
  logic [COLOUR_W-1:0] rd_colour;

  // Move the pending byte out when the output register frees up
  assign pend_mv   = pend_q && (!out_vld_q || m_axis_tready);
  assign pend_free = !pend_q || pend_mv;

  // Take a request only while idle and with room for a pushed byte
  assign s_axis_tready = (state_q == ST_IDLE) && pend_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign rd_go   = (state_q == ST_RUN) && pend_free;
  assign rd_last = (addr_q == '0);

  // Threshold the colour levels into on/off bits
  assign wr_colour = {s_red > LVL_THRESHOLD, s_green > LVL_THRESHOLD, s_blue > LVL_THRESHOLD};
  assign wr_addr   = IDX_W'(s_idx);
  assign wr_en     = s_acc && (s_act == ACT_SET_LED) && (32'(s_idx) < 32'(n_eff));

  lscfd_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_colour),
    .re_i    (rd_go && !blank_q),
    .raddr_i (addr_q),
    .rdata_o (rd_colour)
  );

  // Valid bits: an entry never written reads as all off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    blank_d      = blank_q;
    pend_d       = pend_q;
    pend_ram_d   = pend_ram_q;
    pend_live_d  = pend_live_q;
    pend_byte_d  = pend_byte_q;
    pend_latch_d = pend_latch_q;
    pend_fin_d   = pend_fin_q;

    if (pend_mv) begin
      pend_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (s_act)
            ACT_UPDATE, ACT_BLANK: begin
              // Walk from the last LED down to the first
              state_d = ST_RUN;
              addr_d  = IDX_W'(n_eff - CNT_W'(1));
              blank_d = (s_act == ACT_BLANK);
            end
            ACT_PUSH_COL: begin
              pend_d       = 1'b1;
              pend_ram_d   = 1'b0;
              pend_byte_d  = colour_byte(s_rc, s_gc, s_bc, s_dbl);
              pend_latch_d = 1'b0;
              pend_fin_d   = 1'b1;
            end
            ACT_PUSH_SPACE: begin
              pend_d       = 1'b1;
              pend_ram_d   = 1'b0;
              pend_byte_d  = 8'h00;
              pend_latch_d = 1'b0;
              pend_fin_d   = 1'b1;
            end
            default: begin
              // Set led is handled by the store write; unknown actions drop
            end
          endcase
        end
      end
      ST_RUN: begin
        if (rd_go) begin
          pend_d       = 1'b1;
          pend_ram_d   = !blank_q;
          pend_live_d  = vld_q[addr_q];
          pend_byte_d  = LATCH_EN;
          pend_latch_d = rd_last;
          pend_fin_d   = rd_last;
          addr_d       = addr_q - IDX_W'(1);
          if (rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d   = out_vld_q;
    out_byte_d  = out_byte_q;
    out_latch_d = out_latch_q;
    out_fin_d   = out_fin_q;
    if (pend_mv) begin
      out_vld_d   = 1'b1;
      out_latch_d = pend_latch_q;
      out_fin_d   = pend_fin_q;
      if (pend_ram_q) begin
        out_byte_d = stored_byte(pend_live_q ? rd_colour : '0);
      end else begin
        out_byte_d = pend_byte_q;
      end
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      blank_q   <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      blank_q   <= blank_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    pend_ram_q   <= pend_ram_d;
    pend_live_q  <= pend_live_d;
    pend_byte_q  <= pend_byte_d;
    pend_latch_q <= pend_latch_d;
    pend_fin_q   <= pend_fin_d;
    out_byte_q   <= out_byte_d;
    out_latch_q  <= out_latch_d;
    out_fin_q    <= out_fin_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_latch_q;
  assign m_axis_tlast  = out_fin_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latch_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("latch flagged on a byte that is not the last");

  a_read_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_go |=> pend_q)
    else $error("issued store read lost before the pending stage");

  a_no_accept_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> !s_axis_tready)
    else $error("request taken while a frame walk is in progress");

  a_addr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> 32'(addr_q) < MAX_LEDS)
    else $error("store read address beyond the strip");

  a_pend_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !pend_mv |-> !rd_go && !(s_acc && (s_act == ACT_PUSH_COL ||
                                               s_act == ACT_PUSH_SPACE)))
    else $error("pending byte overwritten before it moved out");

endmodule
